// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the pixel write block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dmpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpw_pkg
// Types, constants and the dither table of the dithered masked pixel write.
// ----------------------------------------------------------------------------
package dmpw_pkg;

  // Frame store geometry defaults
  localparam int STORE_WIDTH_DEF  = 1024;
  localparam int STORE_HEIGHT_DEF = 512;

  // Fixed field widths
  localparam int ADDR_W     = 19;
  localparam int PIXEL_W    = 16;
  localparam int COLOR_W    = 24;
  localparam int POS_W      = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Queue depths
  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 2;

  // Ordered dither table, indexed by {row[1:0], col[1:0]}
  localparam logic signed [3:0] DITHER_LUT [16] = '{
    -4'sd4,  4'sd0, -4'sd3,  4'sd1,
     4'sd2, -4'sd1,  4'sd3, -4'sd1,
    -4'sd3,  4'sd1, -4'sd4,  4'sd0,
     4'sd3, -4'sd1,  4'sd2, -4'sd2
  };

  // Result outcome codes
  typedef enum logic [1:0] {
    OUT_WRITTEN = 2'd0,
    OUT_CLIPPED = 2'd1,
    OUT_BLOCKED = 2'd2
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_AREA_LEFT   = 3'd0,
    REG_AREA_RIGHT  = 3'd1,
    REG_AREA_TOP    = 3'd2,
    REG_AREA_BOTTOM = 3'd3,
    REG_OFFSET_X    = 3'd4,
    REG_OFFSET_Y    = 3'd5,
    REG_MASK_SET    = 3'd6,
    REG_MASK_ENABLE = 3'd7
  } reg_idx_t;

  // Configuration state
  typedef struct packed {
    logic [9:0]  area_left;
    logic [9:0]  area_right;
    logic [8:0]  area_top;
    logic [8:0]  area_bottom;
    logic [10:0] offset_x;
    logic [10:0] offset_y;
    logic        mask_set;
    logic        mask_enable;
  } cfg_t;

  // Classified pixel command, front to back
  typedef struct packed {
    logic               clip;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] pixel;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [1:0]         outcome;
    logic [ADDR_W-1:0]  address;
    logic [PIXEL_W-1:0] pixel;
  } result_t;

endpackage

// ===== hdl/dmpw_fifo.sv =====
// ----------------------------------------------------------------------------
// dmpw_fifo
// Small register FIFO with first-word fall-through read data.
// ----------------------------------------------------------------------------
module dmpw_fifo #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW:0]      wptr_r, wptr_nxt;
  logic [PW:0]      rptr_r, rptr_nxt;
  logic             do_wr, do_rd;

  // Pointer compare
  assign full    = (wptr_r[PW] != rptr_r[PW]) && (wptr_r[PW-1:0] == rptr_r[PW-1:0]);
  assign empty   = (wptr_r == rptr_r);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r[PW-1:0]];

  // Advance pointers
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_wr) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  // Store word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r[PW-1:0]] <= wr_data;
    end
  end

endmodule

// ===== hdl/dmpw_front.sv =====
// ----------------------------------------------------------------------------
// dmpw_front
// Accepts pixel words, applies the offset, clips, dithers and packs them.
// ----------------------------------------------------------------------------
module dmpw_front #(
  parameter int STORE_WIDTH  = dmpw_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = dmpw_pkg::STORE_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dmpw_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic [dmpw_pkg::POS_W-1:0]    in_pos_x,
  input  logic [dmpw_pkg::POS_W-1:0]    in_pos_y,
  input  logic [dmpw_pkg::COLOR_W-1:0]  in_color,
  input  logic                          in_dither_on,
  input  logic                          clr_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output dmpw_pkg::cmd_t                q_wdata
);

  localparam int CW = $clog2(STORE_WIDTH);
  localparam int RW = $clog2(STORE_HEIGHT);
  localparam int AW = $clog2(STORE_WIDTH * STORE_HEIGHT);

  logic                         f_valid_r, f_valid_nxt;
  logic [dmpw_pkg::POS_W-1:0]   f_x_r, f_y_r;
  logic [dmpw_pkg::COLOR_W-1:0] f_color_r;
  logic                         f_dith_r;
  logic                         accept;
  logic                         clip;
  logic [AW-1:0]                addr;
  logic signed [3:0]            dval;
  logic [7:0]                   ch0, ch1, ch2;

  // Add the dither step to one channel and clamp to 0..255
  function automatic logic [7:0] dith_ch(input logic [7:0] c, input logic signed [3:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, c}) + 10'(d);
    if (s[9]) begin
      dith_ch = 8'd0;
    end else if (s[8]) begin
      dith_ch = 8'd255;
    end else begin
      dith_ch = s[7:0];
    end
  endfunction

  // Handshake: stall while clearing or while the staged word cannot drain
  assign full   = clr_busy || (f_valid_r && q_full);
  assign accept = push && !full;
  assign q_push = f_valid_r && !q_full;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Capture word with offset applied, 16-bit wrap
  always_ff @(posedge clk) begin
    if (accept) begin
      f_x_r     <= in_pos_x + {5'b0, cfg.offset_x};
      f_y_r     <= in_pos_y + {5'b0, cfg.offset_y};
      f_color_r <= in_color;
      f_dith_r  <= in_dither_on;
    end
  end

  // Clip against drawing area and store bounds
  assign clip = (f_x_r > dmpw_pkg::POS_W'(cfg.area_right))  ||
                (f_x_r < dmpw_pkg::POS_W'(cfg.area_left))   ||
                (f_y_r > dmpw_pkg::POS_W'(cfg.area_bottom)) ||
                (f_y_r < dmpw_pkg::POS_W'(cfg.area_top))    ||
                (f_x_r >= dmpw_pkg::POS_W'(STORE_WIDTH))    ||
                (f_y_r >= dmpw_pkg::POS_W'(STORE_HEIGHT));

  assign addr = AW'(f_x_r[CW-1:0]) + AW'(f_y_r[RW-1:0]) * AW'(STORE_WIDTH);

  // Ordered dither then 5:5:5 pack
  assign dval = dmpw_pkg::DITHER_LUT[{f_y_r[1:0], f_x_r[1:0]}];
  assign ch0  = f_dith_r ? dith_ch(f_color_r[7:0], dval)   : f_color_r[7:0];
  assign ch1  = f_dith_r ? dith_ch(f_color_r[15:8], dval)  : f_color_r[15:8];
  assign ch2  = f_dith_r ? dith_ch(f_color_r[23:16], dval) : f_color_r[23:16];

  always_comb begin
    q_wdata.clip  = clip;
    q_wdata.addr  = clip ? '0 : dmpw_pkg::ADDR_W'(addr);
    q_wdata.pixel = {cfg.mask_set, ch2[7:3], ch1[7:3], ch0[7:3]};
  end

endmodule

// ===== hdl/dmpw_back.sv =====
// ----------------------------------------------------------------------------
// dmpw_back
// Mask check and write against the frame store's mask-bit memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmpw_back #(
  parameter int STORE_WIDTH  = dmpw_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = dmpw_pkg::STORE_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mask_enable,
  input  dmpw_pkg::cmd_t      q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                res_push,
  output dmpw_pkg::result_t   res_data,
  input  logic                res_full,
  output logic                clr_busy
);

  localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Only bit 15 of a stored pixel is ever read back, so only it is kept
  logic mem [DEPTH];

  logic           clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           rd_valid_r, rd_valid_nxt;
  dmpw_pkg::cmd_t rd_cmd_r;
  logic           rd_bit_r;
  logic           fwd_r, fwd_bit_r;
  logic           rd_done;
  logic           deq;
  logic           stored_bit;
  logic           blocked;
  logic           we_item;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic           mem_wbit;

  assign clr_busy = clr_busy_r;

  // Pipeline control
  assign rd_done  = rd_valid_r && !res_full;
  assign deq      = !clr_busy_r && !q_empty && (!rd_valid_r || rd_done);
  assign q_pop    = deq;
  assign res_push = rd_done;

  // Decide: forward the write retired in the same cycle as the read
  assign stored_bit = fwd_r ? fwd_bit_r : rd_bit_r;
  assign blocked    = !rd_cmd_r.clip && mask_enable && stored_bit;
  assign we_item    = rd_done && !rd_cmd_r.clip && !blocked;

  always_comb begin
    if (rd_cmd_r.clip) begin
      res_data.outcome = dmpw_pkg::OUT_CLIPPED;
      res_data.address = '0;
      res_data.pixel   = '0;
    end else if (blocked) begin
      res_data.outcome = dmpw_pkg::OUT_BLOCKED;
      res_data.address = rd_cmd_r.addr;
      res_data.pixel   = '0;
    end else begin
      res_data.outcome = dmpw_pkg::OUT_WRITTEN;
      res_data.address = rd_cmd_r.addr;
      res_data.pixel   = rd_cmd_r.pixel;
    end
  end

  // Memory write: clearing sweep or a retired pixel
  assign mem_we    = clr_busy_r || we_item;
  assign mem_waddr = clr_busy_r ? clr_addr_r : rd_cmd_r.addr[AW-1:0];
  assign mem_wbit  = clr_busy_r ? 1'b0 : rd_cmd_r.pixel[dmpw_pkg::PIXEL_W-1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wbit;
    end
    if (deq) begin
      rd_bit_r <= mem[q_rdata.addr[AW-1:0]];
    end
  end

  // Capture command and forward info on dequeue
  always_ff @(posedge clk) begin
    if (deq) begin
      rd_cmd_r  <= q_rdata;
      fwd_r     <= we_item && (rd_cmd_r.addr == q_rdata.addr);
      fwd_bit_r <= rd_cmd_r.pixel[dmpw_pkg::PIXEL_W-1];
    end
  end

  // Stage valid and clearing sweep
  always_comb begin
    rd_valid_nxt = rd_valid_r;
    if (deq) begin
      rd_valid_nxt = 1'b1;
    end else if (rd_done) begin
      rd_valid_nxt = 1'b0;
    end
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
        clr_addr_nxt = '0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  `ASSERT_CLK(a_no_deq_clear, clk, rst_n, clr_busy_r |-> !deq, "dequeue during clear")
  `ASSERT_CLK(a_clip_no_write, clk, rst_n, (rd_valid_r && rd_cmd_r.clip) |-> !we_item, "clipped pixel written")
  `ASSERT_CLK(a_clear_done, clk, rst_n, $fell(clr_busy_r) |-> (clr_addr_r == '0), "clear sweep end")

endmodule

// ===== hdl/dithered_masked_pixel_write.sv =====
// A word passes the front stage, command queue, back stage and result queue; one
//   word per cycle unless a queue fills or a clear runs. The mask-bit memory does
//   one read and one write per cycle, bypassed for back-to-back same-address words.
// Reset: synchronous rst_n clears control state and config; a clearing sweep then
//   zeroes all STORE_WIDTH*STORE_HEIGHT mask bits and holds full high.
// ----------------------------------------------------------------------------
// dithered_masked_pixel_write
// Top level: configuration registers, front classifier, queues, back writer.
// ----------------------------------------------------------------------------
module dithered_masked_pixel_write #(
  parameter int STORE_WIDTH  = dmpw_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = dmpw_pkg::STORE_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input queue side
  input  logic                              push,
  output logic                              full,
  input  logic [dmpw_pkg::POS_W-1:0]        in_pos_x,
  input  logic [dmpw_pkg::POS_W-1:0]        in_pos_y,
  input  logic [dmpw_pkg::COLOR_W-1:0]      in_color,
  input  logic                              in_dither_on,
  // Result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        out_outcome,
  output logic [dmpw_pkg::ADDR_W-1:0]       out_address,
  output logic [dmpw_pkg::PIXEL_W-1:0]      out_pixel,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmpw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dmpw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dmpw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  dmpw_pkg::cfg_t    cfg_r, cfg_nxt;
  dmpw_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  dmpw_pkg::cmd_t    q_wdata, q_rdata;
  logic              q_push, q_full, q_empty, q_pop;
  dmpw_pkg::result_t res_data, res_rdata;
  logic              res_push, res_full;
  logic              clr_busy;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = dmpw_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        dmpw_pkg::REG_AREA_LEFT:   cfg_nxt.area_left   = pwdata[9:0];
        dmpw_pkg::REG_AREA_RIGHT:  cfg_nxt.area_right  = pwdata[9:0];
        dmpw_pkg::REG_AREA_TOP:    cfg_nxt.area_top    = pwdata[8:0];
        dmpw_pkg::REG_AREA_BOTTOM: cfg_nxt.area_bottom = pwdata[8:0];
        dmpw_pkg::REG_OFFSET_X:    cfg_nxt.offset_x    = pwdata[10:0];
        dmpw_pkg::REG_OFFSET_Y:    cfg_nxt.offset_y    = pwdata[10:0];
        dmpw_pkg::REG_MASK_SET:    cfg_nxt.mask_set    = pwdata[0];
        dmpw_pkg::REG_MASK_ENABLE: cfg_nxt.mask_enable = pwdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      dmpw_pkg::REG_AREA_LEFT:   prdata = 32'(cfg_r.area_left);
      dmpw_pkg::REG_AREA_RIGHT:  prdata = 32'(cfg_r.area_right);
      dmpw_pkg::REG_AREA_TOP:    prdata = 32'(cfg_r.area_top);
      dmpw_pkg::REG_AREA_BOTTOM: prdata = 32'(cfg_r.area_bottom);
      dmpw_pkg::REG_OFFSET_X:    prdata = 32'(cfg_r.offset_x);
      dmpw_pkg::REG_OFFSET_Y:    prdata = 32'(cfg_r.offset_y);
      dmpw_pkg::REG_MASK_SET:    prdata = 32'(cfg_r.mask_set);
      dmpw_pkg::REG_MASK_ENABLE: prdata = 32'(cfg_r.mask_enable);
      default:                   prdata = '0;
    endcase
  end

  // Front: offset, clip, dither, pack
  dmpw_front #(
    .STORE_WIDTH  (STORE_WIDTH),
    .STORE_HEIGHT (STORE_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push         (push),
    .full         (full),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_color     (in_color),
    .in_dither_on (in_dither_on),
    .clr_busy     (clr_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Command queue between front and back
  dmpw_fifo #(
    .WIDTH (($bits(dmpw_pkg::cmd_t))),
    .DEPTH (dmpw_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back: mask check and store write
  dmpw_back #(
    .STORE_WIDTH  (STORE_WIDTH),
    .STORE_HEIGHT (STORE_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mask_enable (cfg_r.mask_enable),
    .q_rdata     (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .res_push    (res_push),
    .res_data    (res_data),
    .res_full    (res_full),
    .clr_busy    (clr_busy)
  );

  // Result queue
  dmpw_fifo #(
    .WIDTH (($bits(dmpw_pkg::result_t))),
    .DEPTH (dmpw_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rdata),
    .empty   (empty)
  );

  assign out_outcome = res_rdata.outcome;
  assign out_address = res_rdata.address;
  assign out_pixel   = res_rdata.pixel;

endmodule
